/* src/mpba_pkg.sv */
// Shared types and constants for the masked pixel binning accumulator.
package mpba_pkg;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int RES_W      = 3;
   localparam int PIX_W      = 16;
   localparam int VALUE_W    = 32;
   localparam int FLAGS_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int OUT_SUM_W  = 56;
   localparam int OUT_HITS_W = 24;
   localparam int SEEN_W     = 16;
   localparam int BASE_PIXELS = 12;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // register index, taken from paddr[2]
   localparam logic REG_QUALITY_MASK = 1'b0;
   localparam logic REG_RESOLUTION   = 1'b1;
   localparam logic [RES_W-1:0] RESOLUTION_RESET = 3'd6;

   localparam logic CMD_ACCUMULATE = 1'b0;
   localparam logic CMD_DRAIN      = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_ENTRY = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   typedef enum logic [1:0] {
      OP_ACCUMULATE,
      OP_DRAIN,
      OP_RANGE_ERROR
   } op_kind_type;

   typedef struct packed {
      op_kind_type          kind;
      logic [PIX_W-1:0]     pixel;
      logic [VALUE_W-1:0]   value;
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* src/mpba_front.sv */
// Front end: accepts items, drops masked samples, range-checks pixels, queues work.
module mpba_front #(
   parameter int MAX_RESOLUTION_LOG2 = 6
) (
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic [mpba_pkg::FLAGS_W-1:0]   req_sample_flags,
   input  logic [mpba_pkg::PIX_W-1:0]     req_pixel_number,
   input  logic [mpba_pkg::VALUE_W-1:0]   req_sample_value,
   input  logic [mpba_pkg::FLAGS_W-1:0]   quality_mask,
   input  logic [mpba_pkg::RES_W-1:0]     resolution_log2,
   input  mpba_pkg::queue_status_type     q_status,
   input  logic                           clearing,
   output logic                           push,
   output mpba_pkg::op_type               push_op
);
   import mpba_pkg::*;

   localparam int DEPTH  = BASE_PIXELS << (2 * MAX_RESOLUTION_LOG2);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CMP_W  = (ADDR_W > PIX_W) ? ADDR_W : PIX_W;

   logic [RES_W-1:0] res_eff;
   logic [CMP_W-1:0] npix;
   logic             masked;
   logic             out_of_range;
   logic             accept;

   assign res_eff = (32'(resolution_log2) > 32'(MAX_RESOLUTION_LOG2))
                    ? RES_W'(MAX_RESOLUTION_LOG2) : resolution_log2;
   assign npix         = CMP_W'(BASE_PIXELS) << {res_eff, 1'b0};
   assign masked       = (req_sample_flags & quality_mask) != '0;
   assign out_of_range = CMP_W'(req_pixel_number) >= npix;

   assign req_stall = q_status.full || clearing;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      push_op.pixel = req_pixel_number;
      push_op.value = req_sample_value;
      push_op.kind  = OP_ACCUMULATE;
      push          = 1'b0;
      if (req_cmd == CMD_DRAIN) begin
         push_op.kind = OP_DRAIN;
         push         = accept;
      end else if (!masked) begin
         push_op.kind = out_of_range ? OP_RANGE_ERROR : OP_ACCUMULATE;
         push         = accept;
      end
   end

endmodule

/* src/mpba_queue.sv */
// Small FIFO of classified operations between front and back.
module mpba_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  mpba_pkg::op_type            push_op,
   input  logic                        pop,
   output mpba_pkg::op_type            head_op,
   output mpba_pkg::queue_status_type  q_status
);
   import mpba_pkg::*;

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head_op        = entry_ff[rd_ptr_ff];
   assign q_status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_status.empty = count_ff == '0;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

/* src/mpba_back.sv */
// Back end: pixel memory and its clear, read-modify-write of samples, drain scan and result register.
module mpba_back #(
   parameter int MAX_RESOLUTION_LOG2 = 6,
   parameter int SUM_WIDTH           = 56,
   parameter int HIT_WIDTH           = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mpba_pkg::op_type                   head_op,
   input  mpba_pkg::queue_status_type         q_status,
   output logic                               pop,
   output logic                               clearing,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [mpba_pkg::STATUS_W-1:0]      rsp_status,
   output logic [mpba_pkg::PIX_W-1:0]         rsp_out_pixel,
   output logic signed [mpba_pkg::OUT_SUM_W-1:0] rsp_out_sum,
   output logic [mpba_pkg::OUT_HITS_W-1:0]    rsp_out_hits,
   output logic signed [mpba_pkg::VALUE_W-1:0] rsp_min_value,
   output logic signed [mpba_pkg::VALUE_W-1:0] rsp_max_value,
   output logic [mpba_pkg::SEEN_W-1:0]        rsp_seen_pixels,
   output logic                               rsp_last
);
   import mpba_pkg::*;

   localparam int DEPTH  = BASE_PIXELS << (2 * MAX_RESOLUTION_LOG2);
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int MEM_W  = SUM_WIDTH + HIT_WIDTH;
   localparam int SX_W   = (SUM_WIDTH > OUT_SUM_W) ? SUM_WIDTH : OUT_SUM_W;
   localparam int HX_W   = (HIT_WIDTH > OUT_HITS_W) ? HIT_WIDTH : OUT_HITS_W;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
   localparam logic signed [SX_W-1:0] OUT_SUM_HI = SX_W'({1'b0, {(OUT_SUM_W-1){1'b1}}});
   localparam logic signed [SX_W-1:0] OUT_SUM_LO = -OUT_SUM_HI - 1;
   localparam logic [HX_W-1:0] OUT_HITS_HI = HX_W'({OUT_HITS_W{1'b1}});

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ACC   = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [MEM_W-1:0]        mem [DEPTH];
   logic [MEM_W-1:0]        rd_data_ff;
   logic                    mem_we, mem_re;
   logic [ADDR_W-1:0]       mem_waddr, mem_raddr;
   logic [MEM_W-1:0]        mem_wdata;

   logic [2:0]              state_ff, state_in;
   logic [ADDR_W-1:0]       clr_addr_ff, clr_addr_in;
   logic [ADDR_W-1:0]       ptr_ff, ptr_in;
   logic [ADDR_W-1:0]       tag_ff, tag_in;
   logic                    pend_ff, pend_in;
   logic [ADDR_W-1:0]       acc_addr_ff, acc_addr_in;
   logic signed [VALUE_W-1:0] acc_value_ff, acc_value_in;
   logic [CNT_W-1:0]        outstanding_ff, outstanding_in;
   logic [SEEN_W-1:0]       seen_ff, seen_in;
   logic signed [VALUE_W-1:0] run_min_ff, run_min_in;
   logic signed [VALUE_W-1:0] run_max_ff, run_max_in;
   logic                    ext_valid_ff, ext_valid_in;

   logic                    out_valid_ff, out_valid_in;
   logic                    out_load;
   logic [STATUS_W-1:0]     out_status_ff, out_status_in;
   logic [PIX_W-1:0]        out_pixel_ff, out_pixel_in;
   logic signed [OUT_SUM_W-1:0] out_sum_ff, out_sum_in;
   logic [OUT_HITS_W-1:0]   out_hits_ff, out_hits_in;
   logic signed [VALUE_W-1:0] out_min_ff, out_min_in;
   logic signed [VALUE_W-1:0] out_max_ff, out_max_in;
   logic [SEEN_W-1:0]       out_seen_ff, out_seen_in;
   logic                    out_last_ff, out_last_in;

   logic [HIT_WIDTH-1:0]    rd_hit;
   logic signed [SUM_WIDTH-1:0] rd_sum;
   logic [HIT_WIDTH-1:0]    hit_next;
   logic signed [SUM_WIDTH:0] sum_wide;
   logic signed [SUM_WIDTH-1:0] sum_next;
   logic signed [SX_W-1:0]  sum_x;
   logic [HX_W-1:0]         hit_x;
   logic signed [OUT_SUM_W-1:0] sum_clamped;
   logic [OUT_HITS_W-1:0]   hit_clamped;
   logic                    out_free;
   logic                    found;
   logic [ADDR_W-1:0]       ptr_step;
   logic [ADDR_W-1:0]       head_addr;

   assign rd_hit    = rd_data_ff[HIT_WIDTH-1:0];
   assign rd_sum    = rd_data_ff[MEM_W-1:HIT_WIDTH];
   assign hit_next  = (rd_hit == '1) ? rd_hit : rd_hit + 1'b1;
   assign sum_wide  = (SUM_WIDTH+1)'(rd_sum) + (SUM_WIDTH+1)'(acc_value_ff);
   assign sum_x     = SX_W'(rd_sum);
   assign hit_x     = HX_W'(rd_hit);
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign found     = pend_ff && (rd_hit != '0);
   assign ptr_step  = (ptr_ff == LAST_ADDR) ? '0 : ptr_ff + 1'b1;
   assign head_addr = ADDR_W'(head_op.pixel);
   assign clearing  = state_ff == ST_CLEAR;

   always_comb begin
      if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
         sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                        : {1'b0, {(SUM_WIDTH-1){1'b1}}};
      end else begin
         sum_next = sum_wide[SUM_WIDTH-1:0];
      end
      if (sum_x > OUT_SUM_HI) begin
         sum_clamped = {1'b0, {(OUT_SUM_W-1){1'b1}}};
      end else if (sum_x < OUT_SUM_LO) begin
         sum_clamped = {1'b1, {(OUT_SUM_W-1){1'b0}}};
      end else begin
         sum_clamped = OUT_SUM_W'(sum_x);
      end
      hit_clamped = (hit_x > OUT_HITS_HI) ? {OUT_HITS_W{1'b1}} : OUT_HITS_W'(hit_x);
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      ptr_in         = ptr_ff;
      tag_in         = tag_ff;
      pend_in        = pend_ff;
      acc_addr_in    = acc_addr_ff;
      acc_value_in   = acc_value_ff;
      outstanding_in = outstanding_ff;
      seen_in        = seen_ff;
      run_min_in     = run_min_ff;
      run_max_in     = run_max_ff;
      ext_valid_in   = ext_valid_ff;
      pop            = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = clr_addr_ff;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = head_addr;
      out_load       = 1'b0;
      out_status_in  = STATUS_ENTRY;
      out_pixel_in   = '0;
      out_sum_in     = '0;
      out_hits_in    = '0;
      out_min_in     = '0;
      out_max_in     = '0;
      out_seen_in    = '0;
      out_last_in    = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               case (head_op.kind)
                  OP_ACCUMULATE: begin
                     pop          = 1'b1;
                     mem_re       = 1'b1;
                     acc_addr_in  = head_addr;
                     acc_value_in = head_op.value;
                     state_in     = ST_ACC;
                  end
                  OP_RANGE_ERROR: begin
                     if (out_free) begin
                        pop           = 1'b1;
                        out_load      = 1'b1;
                        out_status_in = STATUS_RANGE;
                     end
                  end
                  OP_DRAIN: begin
                     if (outstanding_ff != '0) begin
                        pop      = 1'b1;
                        pend_in  = 1'b0;
                        state_in = ST_SCAN;
                     end else if (out_free) begin
                        pop           = 1'b1;
                        out_load      = 1'b1;
                        out_status_in = STATUS_EMPTY;
                        out_last_in   = 1'b1;
                        ptr_in        = '0;
                        seen_in       = '0;
                        run_min_in    = '0;
                        run_max_in    = '0;
                        ext_valid_in  = 1'b0;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         ST_ACC: begin
            mem_we    = 1'b1;
            mem_waddr = acc_addr_ff;
            mem_wdata = {sum_next, hit_next};
            if (!ext_valid_ff || acc_value_ff < run_min_ff) begin
               run_min_in = acc_value_ff;
            end
            if (!ext_valid_ff || acc_value_ff > run_max_ff) begin
               run_max_in = acc_value_ff;
            end
            ext_valid_in = 1'b1;
            if (rd_hit == '0) begin
               outstanding_in = outstanding_ff + 1'b1;
               seen_in        = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            if (found) begin
               state_in = ST_EMIT;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff;
               tag_in    = ptr_ff;
               pend_in   = 1'b1;
               ptr_in    = ptr_step;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_status_in = STATUS_ENTRY;
               out_pixel_in  = PIX_W'(tag_ff);
               out_sum_in    = sum_clamped;
               out_hits_in   = hit_clamped;
               out_min_in    = run_min_ff;
               out_max_in    = run_max_ff;
               out_seen_in   = seen_ff;
               out_last_in   = outstanding_ff == CNT_W'(1);
               mem_we        = 1'b1;
               mem_waddr     = tag_ff;
               pend_in       = 1'b0;
               state_in      = ST_IDLE;
               if (outstanding_ff == CNT_W'(1)) begin
                  outstanding_in = '0;
                  ptr_in         = '0;
                  seen_in        = '0;
                  run_min_in     = '0;
                  run_max_in     = '0;
                  ext_valid_in   = 1'b0;
               end else begin
                  outstanding_in = outstanding_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_CLEAR;
         clr_addr_ff    <= '0;
         ptr_ff         <= '0;
         pend_ff        <= 1'b0;
         outstanding_ff <= '0;
         seen_ff        <= '0;
         run_min_ff     <= '0;
         run_max_ff     <= '0;
         ext_valid_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clr_addr_ff    <= clr_addr_in;
         ptr_ff         <= ptr_in;
         pend_ff        <= pend_in;
         outstanding_ff <= outstanding_in;
         seen_ff        <= seen_in;
         run_min_ff     <= run_min_in;
         run_max_ff     <= run_max_in;
         ext_valid_ff   <= ext_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff       <= tag_in;
      acc_addr_ff  <= acc_addr_in;
      acc_value_ff <= acc_value_in;
      if (out_load) begin
         out_status_ff <= out_status_in;
         out_pixel_ff  <= out_pixel_in;
         out_sum_ff    <= out_sum_in;
         out_hits_ff   <= out_hits_in;
         out_min_ff    <= out_min_in;
         out_max_ff    <= out_max_in;
         out_seen_ff   <= out_seen_in;
         out_last_ff   <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_out_pixel   = out_pixel_ff;
   assign rsp_out_sum     = out_sum_ff;
   assign rsp_out_hits    = out_hits_ff;
   assign rsp_min_value   = out_min_ff;
   assign rsp_max_value   = out_max_ff;
   assign rsp_seen_pixels = out_seen_ff;
   assign rsp_last        = out_last_ff;

endmodule

/* src/masked_pixel_binning_accumulator.sv */
// Top level: pixel binning accumulator with quality masking and sparse drain.
// Items enter a four-entry queue at up to one per cycle while req_stall is low; the back end then
// handles an accumulated sample as a memory read followed by an add and write back, an out-of-range
// error as a single result, and a drain by walking memory entries to the next hit pixel (one
// entry per cycle over the single read port, up to 12 * 4**MAX_RESOLUTION_LOG2 entries). Masked
// samples are dropped at the input and take no back-end time. After reset the block zeroes the
// pixel memory (12 * 4**MAX_RESOLUTION_LOG2 entries, 49152 by default), one entry a cycle,
// holding req_stall high; register writes are taken during that time.
module masked_pixel_binning_accumulator #(
   parameter int MAX_RESOLUTION_LOG2 = 6,
   parameter int SUM_WIDTH           = 56,
   parameter int HIT_WIDTH           = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [mpba_pkg::FLAGS_W-1:0]          req_sample_flags,
   input  logic [mpba_pkg::PIX_W-1:0]            req_pixel_number,
   input  logic signed [mpba_pkg::VALUE_W-1:0]   req_sample_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [mpba_pkg::STATUS_W-1:0]         rsp_status,
   output logic [mpba_pkg::PIX_W-1:0]            rsp_out_pixel,
   output logic signed [mpba_pkg::OUT_SUM_W-1:0] rsp_out_sum,
   output logic [mpba_pkg::OUT_HITS_W-1:0]       rsp_out_hits,
   output logic signed [mpba_pkg::VALUE_W-1:0]   rsp_min_value,
   output logic signed [mpba_pkg::VALUE_W-1:0]   rsp_max_value,
   output logic [mpba_pkg::SEEN_W-1:0]           rsp_seen_pixels,
   output logic                                  rsp_last,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mpba_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mpba_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   output logic [mpba_pkg::CSR_DATA_W-1:0]       csr_prdata,
   output logic                                  csr_pready
);
   import mpba_pkg::*;

   logic [FLAGS_W-1:0]  quality_mask_ff, quality_mask_in;
   logic [RES_W-1:0]    resolution_ff, resolution_in;
   logic                csr_write;
   queue_status_type    q_status;
   op_type              push_op;
   op_type              head_op;
   logic                push;
   logic                pop;
   logic                clearing;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      quality_mask_in = quality_mask_ff;
      resolution_in   = resolution_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_QUALITY_MASK: quality_mask_in = csr_pwdata;
            REG_RESOLUTION:   resolution_in   = csr_pwdata[RES_W-1:0];
            default: begin
               quality_mask_in = quality_mask_ff;
            end
         endcase
      end
      case (csr_paddr[2])
         REG_QUALITY_MASK: csr_prdata = quality_mask_ff;
         REG_RESOLUTION:   csr_prdata = CSR_DATA_W'(resolution_ff);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quality_mask_ff <= '0;
         resolution_ff   <= RESOLUTION_RESET;
      end else begin
         quality_mask_ff <= quality_mask_in;
         resolution_ff   <= resolution_in;
      end
   end

   mpba_front #(
      .MAX_RESOLUTION_LOG2 (MAX_RESOLUTION_LOG2)
   ) u_front (
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_sample_flags (req_sample_flags),
      .req_pixel_number (req_pixel_number),
      .req_sample_value (req_sample_value),
      .quality_mask     (quality_mask_ff),
      .resolution_log2  (resolution_ff),
      .q_status         (q_status),
      .clearing         (clearing),
      .push             (push),
      .push_op          (push_op)
   );

   mpba_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_op  (push_op),
      .pop      (pop),
      .head_op  (head_op),
      .q_status (q_status)
   );

   mpba_back #(
      .MAX_RESOLUTION_LOG2 (MAX_RESOLUTION_LOG2),
      .SUM_WIDTH           (SUM_WIDTH),
      .HIT_WIDTH           (HIT_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_op         (head_op),
      .q_status        (q_status),
      .pop             (pop),
      .clearing        (clearing),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_pixel   (rsp_out_pixel),
      .rsp_out_sum     (rsp_out_sum),
      .rsp_out_hits    (rsp_out_hits),
      .rsp_min_value   (rsp_min_value),
      .rsp_max_value   (rsp_max_value),
      .rsp_seen_pixels (rsp_seen_pixels),
      .rsp_last        (rsp_last)
   );

endmodule

/* src/mpba_checker.sv */
// Port-level checks on the result channel, bound to the top level.
module mpba_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic [mpba_pkg::STATUS_W-1:0]         rsp_status,
   input logic [mpba_pkg::PIX_W-1:0]            rsp_out_pixel,
   input logic signed [mpba_pkg::OUT_SUM_W-1:0] rsp_out_sum,
   input logic [mpba_pkg::OUT_HITS_W-1:0]       rsp_out_hits,
   input logic [mpba_pkg::SEEN_W-1:0]           rsp_seen_pixels,
   input logic                                  rsp_last
);
   import mpba_pkg::*;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_pixel) && $stable(rsp_out_sum))
      else $error("result changed while stalled");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_last && rsp_out_hits == '0
         && rsp_seen_pixels == '0)
      else $error("empty drain result malformed");

   a_entry_has_hits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_ENTRY |-> rsp_out_hits != '0
         && rsp_seen_pixels != '0)
      else $error("drained pixel without hits");

   a_range_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_RANGE |-> !rsp_last && rsp_out_hits == '0
         && rsp_out_sum == '0)
      else $error("range error result carries data");

endmodule

bind masked_pixel_binning_accumulator mpba_checker u_checker (.*);

/* tb/sv/mpba_bin_monitor.sv */
// Monitor for the pixel binning accumulator: predicts every result and checks each response.
module mpba_bin_monitor #(
   parameter int MAX_RES_LOG2 = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_stall,
   input  logic                                  req_cmd,
   input  logic [mpba_pkg::FLAGS_W-1:0]          req_sample_flags,
   input  logic [mpba_pkg::PIX_W-1:0]            req_pixel_number,
   input  logic signed [mpba_pkg::VALUE_W-1:0]   req_sample_value,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   input  logic [mpba_pkg::STATUS_W-1:0]         rsp_status,
   input  logic [mpba_pkg::PIX_W-1:0]            rsp_out_pixel,
   input  logic signed [mpba_pkg::OUT_SUM_W-1:0] rsp_out_sum,
   input  logic [mpba_pkg::OUT_HITS_W-1:0]       rsp_out_hits,
   input  logic signed [mpba_pkg::VALUE_W-1:0]   rsp_min_value,
   input  logic signed [mpba_pkg::VALUE_W-1:0]   rsp_max_value,
   input  logic [mpba_pkg::SEEN_W-1:0]           rsp_seen_pixels,
   input  logic                                  rsp_last,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [mpba_pkg::CSR_ADDR_W-1:0]       csr_paddr,
   input  logic [mpba_pkg::CSR_DATA_W-1:0]       csr_pwdata,
   input  logic                                  csr_pready,
   output int unsigned                           mismatches,
   output int unsigned                           open_reports
);
   import mpba_pkg::*;

   localparam int MAP_DEPTH = BASE_PIXELS << (2 * MAX_RES_LOG2);
   localparam longint SUM_HI = (longint'(1) <<< (OUT_SUM_W - 1)) - 1;
   localparam longint SUM_LO = -SUM_HI - 1;

   typedef struct packed {
      logic [STATUS_W-1:0]   status;
      logic [PIX_W-1:0]      pixel;
      logic [OUT_SUM_W-1:0]  sum;
      logic [OUT_HITS_W-1:0] hits;
      logic [VALUE_W-1:0]    low;
      logic [VALUE_W-1:0]    high;
      logic [SEEN_W-1:0]     seen;
      logic                  last;
   } bin_report_type;

   logic [OUT_SUM_W-1:0]  bin_sum  [MAP_DEPTH];
   logic [OUT_HITS_W-1:0] bin_hits [MAP_DEPTH];
   int unsigned           seen_total;
   int unsigned           drained_total;
   int unsigned           scan_from;
   logic [VALUE_W-1:0]    low_mark;
   logic [VALUE_W-1:0]    high_mark;
   logic                  marks_valid;
   logic [FLAGS_W-1:0]    skip_mask;
   logic [RES_W-1:0]      res_log2;

   bin_report_type expected_reports [$];
   bin_report_type got_report;
   bin_report_type want_report;
   bin_report_type new_report;

   function automatic void clear_tallies();
      seen_total    = 0;
      drained_total = 0;
      scan_from     = 0;
      low_mark      = '0;
      high_mark     = '0;
      marks_valid   = 1'b0;
   endfunction

   function automatic logic [OUT_SUM_W-1:0] sat_add(input logic [OUT_SUM_W-1:0] acc,
                                                    input logic [VALUE_W-1:0] value);
      longint total;
      total = longint'($signed(acc)) + longint'($signed(value));
      if (total > SUM_HI) total = SUM_HI;
      if (total < SUM_LO) total = SUM_LO;
      return total[OUT_SUM_W-1:0];
   endfunction

   // Returns 1 when the item yields a result.
   function automatic bit predict_item(input logic cmd, input logic [FLAGS_W-1:0] flags,
                                       input logic [PIX_W-1:0] pix,
                                       input logic [VALUE_W-1:0] value,
                                       output bin_report_type rep);
      int          eff;
      int unsigned k;
      int unsigned start;
      int unsigned spot;
      bit          found;
      rep = '0;
      if (cmd == CMD_ACCUMULATE) begin
         if ((flags & skip_mask) != 0) return 1'b0;
         eff = (res_log2 > MAX_RES_LOG2) ? MAX_RES_LOG2 : res_log2;
         if (pix >= (BASE_PIXELS << (2 * eff))) begin
            rep.status = STATUS_RANGE;
            return 1'b1;
         end
         bin_sum[pix] = sat_add(bin_sum[pix], value);
         if (!marks_valid || $signed(value) < $signed(low_mark)) low_mark = value;
         if (!marks_valid || $signed(value) > $signed(high_mark)) high_mark = value;
         marks_valid = 1'b1;
         if (bin_hits[pix] != {OUT_HITS_W{1'b1}}) bin_hits[pix] = bin_hits[pix] + 1'b1;
         if (bin_hits[pix] == 1) seen_total++;
         return 1'b0;
      end
      found = 1'b0;
      spot  = 0;
      if (drained_total < seen_total) begin
         start = (scan_from < MAP_DEPTH) ? scan_from : 0;
         for (k = 0; k < MAP_DEPTH && !found; k++) begin
            spot = start + k;
            if (spot >= MAP_DEPTH) spot -= MAP_DEPTH;
            found = (bin_hits[spot] != 0);
         end
      end
      if (!found) begin
         clear_tallies();
         rep.status = STATUS_EMPTY;
         rep.last   = 1'b1;
         return 1'b1;
      end
      rep.status = STATUS_ENTRY;
      rep.pixel  = spot[PIX_W-1:0];
      rep.sum    = bin_sum[spot];
      rep.hits   = bin_hits[spot];
      rep.low    = marks_valid ? low_mark : '0;
      rep.high   = marks_valid ? high_mark : '0;
      rep.seen   = (seen_total > 32'hFFFF) ? {SEEN_W{1'b1}} : seen_total[SEEN_W-1:0];
      bin_sum[spot]  = '0;
      bin_hits[spot] = '0;
      drained_total++;
      scan_from = (spot + 1 < MAP_DEPTH) ? spot + 1 : 0;
      rep.last  = (drained_total >= seen_total);
      // every seen pixel has been read back, so the map entries are already zero
      if (rep.last) clear_tallies();
      return 1'b1;
   endfunction

   function automatic void check_field(input string what, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         skip_mask = '0;
         res_log2  = RESOLUTION_RESET;
         for (int i = 0; i < MAP_DEPTH; i++) begin
            bin_sum[i]  = '0;
            bin_hits[i] = '0;
         end
         clear_tallies();
         expected_reports.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_report = {rsp_status, rsp_out_pixel, rsp_out_sum, rsp_out_hits, rsp_min_value,
                          rsp_max_value, rsp_seen_pixels, rsp_last};
            if (expected_reports.size() == 0) begin
               $display("%0t: result transfer with none expected: expected nothing, got 0x%0h",
                        $time, got_report);
               mismatches++;
            end else begin
               want_report = expected_reports.pop_front();
               check_field("status", want_report.status, got_report.status);
               check_field("out_pixel", want_report.pixel, got_report.pixel);
               check_field("out_sum", want_report.sum, got_report.sum);
               check_field("out_hits", want_report.hits, got_report.hits);
               check_field("min_value", want_report.low, got_report.low);
               check_field("max_value", want_report.high, got_report.high);
               check_field("seen_pixels", want_report.seen, got_report.seen);
               check_field("last", want_report.last, got_report.last);
            end
         end
         if (req_valid && !req_stall &&
             predict_item(req_cmd, req_sample_flags, req_pixel_number, req_sample_value,
                          new_report))
            expected_reports.push_back(new_report);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_QUALITY_MASK) skip_mask = csr_pwdata;
            else res_log2 = csr_pwdata[RES_W-1:0];
         end
      end
      open_reports = expected_reports.size();
   end

endmodule

/* tb/sv/tb_masked_pixel_binning_accumulator.sv */
// Testbench top: drives samples, drains and register writes into the binning accumulator.
module tb_masked_pixel_binning_accumulator;
   import mpba_pkg::*;

   localparam int MAX_RES_LOG2  = 6;
   localparam int MAP_DEPTH     = BASE_PIXELS << (2 * MAX_RES_LOG2);
   localparam int ITEM_TARGET   = 1600;
   localparam int SETTLE_CYCLES = 24;
   localparam int WINDOW        = 48;

   logic                    clock            = 1'b0;
   logic                    reset            = 1'b1;
   logic                    req_valid        = 1'b0;
   logic                    req_stall;
   logic                    req_cmd          = CMD_ACCUMULATE;
   logic [FLAGS_W-1:0]      req_sample_flags = '0;
   logic [PIX_W-1:0]        req_pixel_number = '0;
   logic signed [VALUE_W-1:0] req_sample_value = '0;
   logic                    rsp_valid;
   logic                    rsp_stall        = 1'b0;
   logic [STATUS_W-1:0]     rsp_status;
   logic [PIX_W-1:0]        rsp_out_pixel;
   logic signed [OUT_SUM_W-1:0] rsp_out_sum;
   logic [OUT_HITS_W-1:0]   rsp_out_hits;
   logic signed [VALUE_W-1:0] rsp_min_value;
   logic signed [VALUE_W-1:0] rsp_max_value;
   logic [SEEN_W-1:0]       rsp_seen_pixels;
   logic                    rsp_last;
   logic                    csr_psel         = 1'b0;
   logic                    csr_penable      = 1'b0;
   logic                    csr_pwrite       = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr        = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata       = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   int unsigned             mismatches;
   int unsigned             open_reports;

   int                      send_idle_pct    = 34;
   int                      recv_idle_pct    = 80;
   int                      sent_items       = 0;
   logic [FLAGS_W-1:0]      cur_mask         = '0;
   logic [RES_W-1:0]        cur_res          = RESOLUTION_RESET;
   bit                      pix_taken [MAP_DEPTH];
   int                      taken_list [$];
   int                      pending_pixels   = 0;
   int                      reach            = -1;

   masked_pixel_binning_accumulator #(.MAX_RESOLUTION_LOG2(MAX_RES_LOG2)) dut (.*);

   mpba_bin_monitor #(.MAX_RES_LOG2(MAX_RES_LOG2)) bin_monitor (.*);

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #8000000;
      $display("[masked_pixel_binning_accumulator] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic int map_pixels();
      return BASE_PIXELS << (2 * ((cur_res > MAX_RES_LOG2) ? MAX_RES_LOG2 : cur_res));
   endfunction

   function automatic logic [FLAGS_W-1:0] pick_flags();
      return ($urandom_range(9) < 7) ? ($urandom() & ~cur_mask) : $urandom();
   endfunction

   function automatic int pick_pixel();
      int npix;
      npix = map_pixels();
      if ($urandom_range(9) == 0) return $urandom_range(65535, npix);
      return $urandom_range((npix < WINDOW) ? npix - 1 : WINDOW - 1);
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_0000;
         3: return 32'h0001_0000;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [FLAGS_W-1:0] pick_mask();
      case ($urandom_range(4))
         0: return '0;
         1: return 32'h1 << $urandom_range(31);
         2: return $urandom() & $urandom() & $urandom();
         3: return '1;
         default: return $urandom();
      endcase
   endfunction

   task automatic csr_write(input logic idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == REG_QUALITY_MASK) cur_mask = data;
      else cur_res = data[RES_W-1:0];
   endtask

   task automatic push_item(input logic cmd, input logic [FLAGS_W-1:0] flags,
                            input logic [PIX_W-1:0] pix, input logic [VALUE_W-1:0] value);
      if (sent_items < ITEM_TARGET / 3) begin
         send_idle_pct = 34;
         recv_idle_pct = 80;
      end else if (sent_items < 2 * ITEM_TARGET / 3) begin
         send_idle_pct = 80;
         recv_idle_pct = 34;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_sample_flags <= flags;
      req_pixel_number <= pix;
      req_sample_value <= value;
      do @(posedge clock); while (req_stall);
      if (!(cmd == CMD_ACCUMULATE && (flags & cur_mask) != 0)) sent_items++;
   endtask

   task automatic bin_sample(input logic [FLAGS_W-1:0] flags, input int pix,
                             input logic [VALUE_W-1:0] value);
      push_item(CMD_ACCUMULATE, flags, pix[PIX_W-1:0], value);
      if ((flags & cur_mask) == 0 && pix < map_pixels() && !pix_taken[pix]) begin
         pix_taken[pix] = 1'b1;
         taken_list.push_back(pix);
         pending_pixels++;
         if (pix > reach) reach = pix;
      end
   endtask

   task automatic drain_next();
      push_item(CMD_DRAIN, $urandom(), $urandom_range(65535), $urandom());
      if (pending_pixels > 0) begin
         pending_pixels--;
         if (pending_pixels == 0) begin
            foreach (taken_list[k]) pix_taken[taken_list[k]] = 1'b0;
            taken_list.delete();
            reach = -1;
         end
      end
   endtask

   // hold off until every result has come back and the back end has gone quiet
   task automatic stop_and_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (open_reports != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      csr_write(REG_QUALITY_MASK, 32'h0000_0001);
      csr_write(REG_RESOLUTION, 32'd6);
      drain_next();
      bin_sample(32'h0000_0001, 5, 32'h7FFF_FFFF);
      bin_sample(32'hFFFF_FFFE, 5, 32'h7FFF_FFFF);
      bin_sample(32'h0000_0000, 5, 32'h8000_0000);
      bin_sample(32'h0000_0000, 9, 32'h0000_0000);
      bin_sample(32'h0000_0000, MAP_DEPTH - 1, 32'h0000_0001);
      bin_sample(32'h0000_0000, MAP_DEPTH, 32'h0000_0001);
      bin_sample(32'h0000_0000, 65535, 32'hFFFF_FFFF);
      bin_sample(32'hFFFF_FFFF, 65535, 32'h0000_0000);
      drain_next();
      bin_sample(32'h0000_0000, 2, 32'hFFFB_0000);
      // 9, top pixel, wrap back to 2, then an empty map
      repeat (4) drain_next();

      bin_sample(32'h0000_0000, 700, 32'h0001_2345);
      bin_sample(32'h0000_0000, 700, 32'hFFFE_0000);
      stop_and_drain();
      csr_write(REG_RESOLUTION, 32'd0);
      bin_sample(32'h0000_0000, 12, 32'h0000_0001);
      bin_sample(32'h0000_0000, 11, 32'h0000_8000);
      repeat (2) drain_next();

      stop_and_drain();
      csr_write(REG_RESOLUTION, 32'd7);
      csr_write(REG_QUALITY_MASK, 32'h0000_0000);
      bin_sample(32'h0000_0000, MAP_DEPTH, 32'h0000_0005);
      bin_sample(32'hFFFF_FFFF, 767, 32'h7FFF_FFFF);
      drain_next();

      stop_and_drain();
      csr_write(REG_QUALITY_MASK, 32'hFFFF_FFFF);
      bin_sample(32'h0000_0000, 0, 32'h8000_0000);
      bin_sample(32'h8000_0000, 0, 32'h0000_0001);
      drain_next();

      while (sent_items < ITEM_TARGET) begin
         if ($urandom_range(3) == 0) begin
            stop_and_drain();
            csr_write(REG_QUALITY_MASK, pick_mask());
            csr_write(REG_RESOLUTION, $urandom_range(7));
         end
         repeat ($urandom_range(40, 1)) bin_sample(pick_flags(), pick_pixel(), pick_value());
         while (pending_pixels > 0) begin
            if ($urandom_range(7) == 0) begin
               if ($urandom_range(1) == 0)
                  bin_sample(pick_flags(), $urandom_range(65535, map_pixels()), pick_value());
               else if (reach + 8 < map_pixels())
                  bin_sample(pick_flags(), reach + $urandom_range(8, 1), pick_value());
            end
            drain_next();
         end
         if ($urandom_range(3) == 0) drain_next();
      end

      stop_and_drain();
      if (mismatches == 0) begin
         $display("[masked_pixel_binning_accumulator] OK");
      end else begin
         $display("[masked_pixel_binning_accumulator] ERROR");
      end
      $finish;
   end

endmodule
